/* hw/rtl/first_touch_home_core_directory_defines.svh */
// ---------------------------------------------------------------------------
// First-touch home-core directory: assertion macros
// Shared property wrappers for the checker files.
// ---------------------------------------------------------------------------
`ifndef FIRST_TOUCH_HOME_CORE_DIRECTORY_DEFINES_SVH
`define FIRST_TOUCH_HOME_CORE_DIRECTORY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FTCD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ftcd check failed");

// Next-cycle implication, checked outside reset.
`define FTCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ftcd check failed");

`endif

/* hw/rtl/ftcd_pkg.sv */
// ---------------------------------------------------------------------------
// First-touch home-core directory package
// Sizes, result kinds, register indexes, memory entry layouts and a time helper.
// ---------------------------------------------------------------------------
package ftcd_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
  // Queue depth must be a power of two: slot indexes wrap naturally.
  localparam int QUEUE_DEPTH   = 16;
  localparam int Q_IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int Q_CNT_W       = Q_IDX_W + 1;
  localparam int CORE_BITS     = 10;
  localparam int TIME_W        = 48;
  localparam int ID_W          = 8;
  localparam int PORT_W        = 5;

  // Result kinds
  localparam logic [1:0] KIND_ACCEPT   = 2'd0;
  localparam logic [1:0] KIND_NO_PORT  = 2'd1;
  localparam logic [1:0] KIND_FULL     = 2'd2;
  localparam logic [1:0] KIND_COMPLETE = 2'd3;

  // Configuration register indexes
  localparam logic [3:0] REG_LATENCY  = 4'd0;
  localparam logic [3:0] REG_SYNCH    = 4'd1;
  localparam logic [3:0] REG_PORTS    = 4'd2;
  localparam logic [3:0] REG_UNIT     = 4'd3;

  typedef struct packed {
    logic [TIME_W-1:0]    tag;
    logic [CORE_BITS-1:0] home;
    logic [TIME_W-1:0]    ready;
  } tbl_entry_t;

  typedef struct packed {
    logic [ID_W-1:0]      id;
    logic [CORE_BITS-1:0] home;
    logic [TIME_W-1:0]    ready;
  } que_entry_t;

  // Add two times, saturating at all ones.
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

/* hw/rtl/ftcd_ram.sv */
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module ftcd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read, held while idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hw/rtl/first_touch_home_core_directory.sv */
// ---------------------------------------------------------------------------
// First-touch home-core directory
// Maps byte addresses to home cores by first touch, queues lookups and
// reports their completions on clock ticks.
// ---------------------------------------------------------------------------
// Usage:
//   in_*  : items. in_tuser = operation (0 request, 1 tick); in_tdata holds
//           address, sender and req_id.
//   out_* : results. out_tuser = kind, out_tlast marks the final result of
//           an item; out_tdata holds out_req_id, home_core, first_touch.
//   cfg_* : register writes, taken at any time, meant for idle periods.
// Flow: one item is worked at a time. A request walks the unit table,
//   reading each valid entry through the registered table read and
//   noting the first empty one, then queues and answers or refuses it. A
//   tick walks the pending queue, reading each open request and skipping
//   done ones, then frees one head slot a cycle.
// Reset: valid bits, queue pointers, time and registers return to their
//   reset values under the synchronous reset; no clearing pass is needed.
// Stall: a held result keeps the block in its current step until the
//   receiver takes it; one result register parts the two sides.
// ---------------------------------------------------------------------------
module first_touch_home_core_directory (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // address[47:0], sender[57:48], req_id[65:58]
  input  logic [0:0]  in_tuser,   // operation[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_req_id[7:0], home_core[17:8], first_touch[18]
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int TW = ftcd_pkg::TIME_W;
  localparam int CB = ftcd_pkg::CORE_BITS;
  localparam int IW = ftcd_pkg::ID_W;
  localparam int TI = ftcd_pkg::TBL_IDX_W;
  localparam int QI = ftcd_pkg::Q_IDX_W;
  localparam int QC = ftcd_pkg::Q_CNT_W;
  localparam int PW = ftcd_pkg::PORT_W;

  typedef enum logic [11:0] {
    ST_IDLE   = 12'b0000_0000_0001,
    ST_CHK    = 12'b0000_0000_0010,
    ST_TSCAN  = 12'b0000_0000_0100,
    ST_TCMP   = 12'b0000_0000_1000,
    ST_NEW    = 12'b0000_0001_0000,
    ST_LAT    = 12'b0000_0010_0000,
    ST_ENQ    = 12'b0000_0100_0000,
    ST_REFUSE = 12'b0000_1000_0000,
    ST_QSCAN  = 12'b0001_0000_0000,
    ST_QCMP   = 12'b0010_0000_0000,
    ST_FLUSH  = 12'b0100_0000_0000,
    ST_REL    = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration
  logic [15:0]  lat_r, lat_nxt;
  logic [15:0]  syn_r, syn_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [4:0]   ul_r, ul_nxt;

  // Directory state
  logic [TW-1:0] now_r, now_nxt;
  logic [ftcd_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [ftcd_pkg::QUEUE_DEPTH-1:0]   done_r, done_nxt;
  logic [QI-1:0] head_r, head_nxt;
  logic [QC-1:0] count_r, count_nxt;
  logic [PW-1:0] free_r, free_nxt;

  // Item work registers
  logic [TW-1:0] tag_r, tag_nxt;
  logic [CB-1:0] sender_r, sender_nxt;
  logic [IW-1:0] id_r, id_nxt;
  logic [TI-1:0] idx_r, idx_nxt;
  logic          fresh_vld_r, fresh_vld_nxt;
  logic [TI-1:0] fresh_idx_r, fresh_idx_nxt;
  logic [CB-1:0] home_r, home_nxt;
  logic [TW-1:0] ready_r, ready_nxt;
  logic          ft_r, ft_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [QC-1:0] qi_r, qi_nxt;
  logic          hold_vld_r, hold_vld_nxt;
  logic [IW-1:0] hold_id_r, hold_id_nxt;
  logic [CB-1:0] hold_home_r, hold_home_nxt;

  // Result register
  logic          ovld_r, ovld_nxt;
  logic [1:0]    okind_r, okind_nxt;
  logic [IW-1:0] oid_r, oid_nxt;
  logic [CB-1:0] ohome_r, ohome_nxt;
  logic          oft_r, oft_nxt;
  logic          olast_r, olast_nxt;

  // Memories
  logic                 tbl_wr_en, tbl_rd_en;
  logic [TI-1:0]        tbl_rd_addr;
  ftcd_pkg::tbl_entry_t tbl_wr_data, tbl_rd_data;
  logic                 que_wr_en, que_rd_en;
  logic [QI-1:0]        que_wr_addr, que_rd_addr;
  ftcd_pkg::que_entry_t que_wr_data, que_rd_data;

  logic          out_free;
  logic          tbl_step;
  logic [QI-1:0] qslot;
  logic [QI-1:0] tail;
  logic [TW-1:0] new_ready;

  ftcd_ram #(.Width($bits(ftcd_pkg::tbl_entry_t)), .Depth(ftcd_pkg::TABLE_ENTRIES)) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (fresh_idx_r),
    .wr_data (tbl_wr_data),
    .rd_en   (tbl_rd_en),
    .rd_addr (tbl_rd_addr),
    .rd_data (tbl_rd_data)
  );

  ftcd_ram #(.Width($bits(ftcd_pkg::que_entry_t)), .Depth(ftcd_pkg::QUEUE_DEPTH)) u_que (
    .clk     (clk),
    .wr_en   (que_wr_en),
    .wr_addr (que_wr_addr),
    .wr_data (que_wr_data),
    .rd_en   (que_rd_en),
    .rd_addr (que_rd_addr),
    .rd_data (que_rd_data)
  );

  assign out_free  = !ovld_r || out_tready;
  assign qslot     = head_r + qi_r[QI-1:0];
  assign tail      = head_r + count_r[QI-1:0];
  assign new_ready = ftcd_pkg::sat_add(now_r, TW'(syn_r));

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = ovld_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {5'd0, oft_r, ohome_r, oid_r};

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    lat_nxt       = lat_r;
    syn_nxt       = syn_r;
    pc_nxt        = pc_r;
    ul_nxt        = ul_r;
    now_nxt       = now_r;
    valid_nxt     = valid_r;
    done_nxt      = done_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    free_nxt      = free_r;
    tag_nxt       = tag_r;
    sender_nxt    = sender_r;
    id_nxt        = id_r;
    idx_nxt       = idx_r;
    fresh_vld_nxt = fresh_vld_r;
    fresh_idx_nxt = fresh_idx_r;
    home_nxt      = home_r;
    ready_nxt     = ready_r;
    ft_nxt        = ft_r;
    kind_nxt      = kind_r;
    qi_nxt        = qi_r;
    hold_vld_nxt  = hold_vld_r;
    hold_id_nxt   = hold_id_r;
    hold_home_nxt = hold_home_r;
    ovld_nxt      = ovld_r && !out_tready;
    okind_nxt     = okind_r;
    oid_nxt       = oid_r;
    ohome_nxt     = ohome_r;
    oft_nxt       = oft_r;
    olast_nxt     = olast_r;
    tbl_wr_en     = 1'b0;
    tbl_rd_en     = 1'b0;
    tbl_rd_addr   = idx_r;
    tbl_wr_data   = '{tag: tag_r, home: sender_r, ready: new_ready};
    que_wr_en     = 1'b0;
    que_rd_en     = 1'b0;
    que_wr_addr   = tail;
    que_rd_addr   = qslot;
    que_wr_data   = '{id: id_r, home: home_r, ready: ready_r};
    tbl_step      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          tag_nxt    = in_tdata[47:0] & ({TW{1'b1}} << ul_r);
          sender_nxt = in_tdata[57:48];
          id_nxt     = in_tdata[65:58];
          if (in_tuser[0]) begin
            qi_nxt       = '0;
            hold_vld_nxt = 1'b0;
            state_nxt    = ST_QSCAN;
          end else begin
            state_nxt = ST_CHK;
          end
        end
      end
      // Port and slot check comes first
      ST_CHK: begin
        if ((pc_r == '0 || free_r != '0) && count_r < QC'(ftcd_pkg::QUEUE_DEPTH)) begin
          idx_nxt       = '0;
          fresh_vld_nxt = 1'b0;
          state_nxt     = ST_TSCAN;
        end else begin
          kind_nxt  = ftcd_pkg::KIND_NO_PORT;
          state_nxt = ST_REFUSE;
        end
      end
      // Walk the table: read valid entries, note the first empty one
      ST_TSCAN: begin
        if (valid_r[idx_r]) begin
          tbl_rd_en = 1'b1;
          state_nxt = ST_TCMP;
        end else begin
          if (!fresh_vld_r) begin
            fresh_vld_nxt = 1'b1;
            fresh_idx_nxt = idx_r;
          end
          tbl_step = 1'b1;
        end
      end
      ST_TCMP: begin
        if (tbl_rd_data.tag == tag_r) begin
          home_nxt  = tbl_rd_data.home;
          ready_nxt = (tbl_rd_data.ready > now_r) ? tbl_rd_data.ready : now_r;
          ft_nxt    = 1'b0;
          state_nxt = ST_LAT;
        end else begin
          tbl_step = 1'b1;
        end
      end
      // Place the unit with the sender as home
      ST_NEW: begin
        tbl_wr_en              = 1'b1;
        valid_nxt[fresh_idx_r] = 1'b1;
        home_nxt               = sender_r;
        ready_nxt              = new_ready;
        ft_nxt                 = 1'b1;
        state_nxt              = ST_LAT;
      end
      ST_LAT: begin
        ready_nxt = ftcd_pkg::sat_add(ready_r, TW'(lat_r));
        state_nxt = ST_ENQ;
      end
      // Queue the request and answer it
      ST_ENQ: begin
        if (out_free) begin
          que_wr_en       = 1'b1;
          done_nxt[tail]  = 1'b0;
          count_nxt       = count_r + 1'b1;
          if (pc_r != '0 && free_r != '0) begin
            free_nxt = free_r - 1'b1;
          end
          ovld_nxt  = 1'b1;
          okind_nxt = ftcd_pkg::KIND_ACCEPT;
          oid_nxt   = id_r;
          ohome_nxt = home_r;
          oft_nxt   = ft_r;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_REFUSE: begin
        if (out_free) begin
          ovld_nxt  = 1'b1;
          okind_nxt = kind_r;
          oid_nxt   = id_r;
          ohome_nxt = '0;
          oft_nxt   = 1'b0;
          olast_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      // Walk the queue from the head, skip reported entries
      ST_QSCAN: begin
        if (qi_r == count_r) begin
          state_nxt = ST_FLUSH;
        end else if (done_r[qslot]) begin
          qi_nxt = qi_r + 1'b1;
        end else begin
          que_rd_en = 1'b1;
          state_nxt = ST_QCMP;
        end
      end
      // Hold one completion back so the final one can carry tlast
      ST_QCMP: begin
        if (que_rd_data.ready <= now_r) begin
          if (!hold_vld_r || out_free) begin
            if (hold_vld_r) begin
              ovld_nxt  = 1'b1;
              okind_nxt = ftcd_pkg::KIND_COMPLETE;
              oid_nxt   = hold_id_r;
              ohome_nxt = hold_home_r;
              oft_nxt   = 1'b0;
              olast_nxt = 1'b0;
            end
            hold_vld_nxt    = 1'b1;
            hold_id_nxt     = que_rd_data.id;
            hold_home_nxt   = que_rd_data.home;
            done_nxt[qslot] = 1'b1;
            qi_nxt          = qi_r + 1'b1;
            state_nxt       = ST_QSCAN;
          end
        end else begin
          qi_nxt    = qi_r + 1'b1;
          state_nxt = ST_QSCAN;
        end
      end
      ST_FLUSH: begin
        if (!hold_vld_r) begin
          state_nxt = ST_REL;
        end else if (out_free) begin
          ovld_nxt     = 1'b1;
          okind_nxt    = ftcd_pkg::KIND_COMPLETE;
          oid_nxt      = hold_id_r;
          ohome_nxt    = hold_home_r;
          oft_nxt      = 1'b0;
          olast_nxt    = 1'b1;
          hold_vld_nxt = 1'b0;
          state_nxt    = ST_REL;
        end
      end
      // Release done head slots one a cycle, then advance time
      ST_REL: begin
        if (count_r != '0 && done_r[head_r]) begin
          head_nxt  = head_r + 1'b1;
          count_nxt = count_r - 1'b1;
          if (pc_r != '0 && free_r < pc_r) begin
            free_nxt = free_r + 1'b1;
          end
        end else begin
          now_nxt   = ftcd_pkg::sat_add(now_r, TW'(1));
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Advance the table walk or finish it
    if (tbl_step) begin
      if (idx_r == TI'(ftcd_pkg::TABLE_ENTRIES - 1)) begin
        if (fresh_vld_nxt) begin
          state_nxt = ST_NEW;
        end else begin
          kind_nxt  = ftcd_pkg::KIND_FULL;
          state_nxt = ST_REFUSE;
        end
      end else begin
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ST_TSCAN;
      end
    end

    // Register writes
    if (cfg_valid) begin
      case (cfg_index)
        ftcd_pkg::REG_LATENCY: lat_nxt = cfg_data;
        ftcd_pkg::REG_SYNCH:   syn_nxt = cfg_data;
        ftcd_pkg::REG_PORTS: begin
          pc_nxt   = cfg_data[PW-1:0];
          free_nxt = cfg_data[PW-1:0];
        end
        ftcd_pkg::REG_UNIT:    ul_nxt = cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      lat_r      <= 16'd1;
      syn_r      <= '0;
      pc_r       <= '0;
      ul_r       <= 5'd12;
      now_r      <= '0;
      valid_r    <= '0;
      done_r     <= '0;
      head_r     <= '0;
      count_r    <= '0;
      free_r     <= '0;
      hold_vld_r <= 1'b0;
      ovld_r     <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      lat_r      <= lat_nxt;
      syn_r      <= syn_nxt;
      pc_r       <= pc_nxt;
      ul_r       <= ul_nxt;
      now_r      <= now_nxt;
      valid_r    <= valid_nxt;
      done_r     <= done_nxt;
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      free_r     <= free_nxt;
      hold_vld_r <= hold_vld_nxt;
      ovld_r     <= ovld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    tag_r       <= tag_nxt;
    sender_r    <= sender_nxt;
    id_r        <= id_nxt;
    idx_r       <= idx_nxt;
    fresh_vld_r <= fresh_vld_nxt;
    fresh_idx_r <= fresh_idx_nxt;
    home_r      <= home_nxt;
    ready_r     <= ready_nxt;
    ft_r        <= ft_nxt;
    kind_r      <= kind_nxt;
    qi_r        <= qi_nxt;
    hold_id_r   <= hold_id_nxt;
    hold_home_r <= hold_home_nxt;
    okind_r     <= okind_nxt;
    oid_r       <= oid_nxt;
    ohome_r     <= ohome_nxt;
    oft_r       <= oft_nxt;
    olast_r     <= olast_nxt;
  end

endmodule

/* hw/rtl/ftcd_checker.sv */
// ---------------------------------------------------------------------------
// First-touch home-core directory checker
// Port-level properties of the directory, bound to the top level.
// ---------------------------------------------------------------------------
`include "first_touch_home_core_directory_defines.svh"

module ftcd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // One item at a time: no transfer in the cycle after one
  `FTCD_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready)

  // A request answer is the sole result of its item
  `FTCD_ASSERT_SAME(a_answer_last, out_tvalid && out_tuser != ftcd_pkg::KIND_COMPLETE, out_tlast)

  // Refusals carry no home and no first-touch flag
  `FTCD_ASSERT_SAME(a_refuse_clean,
    out_tvalid && (out_tuser == ftcd_pkg::KIND_NO_PORT || out_tuser == ftcd_pkg::KIND_FULL),
    out_tdata[18:8] == 11'd0)

  // Held result stays put
  `FTCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind first_touch_home_core_directory ftcd_checker u_ftcd_checker (.*);
